// File: rtl/core/alt_pkg.sv
package alt_pkg;

  // Line and token limits.
  localparam int LineLength  = 256;
  localparam int IdentMax    = 63;
  localparam int NumberLimit = 31;
  localparam int ColW        = $clog2(LineLength);
  localparam int LastCol     = LineLength - 1;

  localparam logic [30:0] SatMax         = 31'h7FFF_FFFF;
  localparam logic [6:0]  MaxTokensReset = 7'd16;

  // Result queue depth; two free entries are needed to take a character.
  localparam int QDepth = 4;
  localparam int QPtrW  = $clog2(QDepth);
  localparam int QCntW  = $clog2(QDepth + 1);

  localparam int OutDataW = 56;
  localparam int OutUserW = 3;

  typedef enum logic [2:0] {
    KIND_COMMA    = 3'd0,
    KIND_NUMBER   = 3'd1,
    KIND_LABEL    = 3'd2,
    KIND_LOOP     = 3'd3,
    KIND_MNEMONIC = 3'd4,
    KIND_LINE_END = 3'd5,
    KIND_ERROR    = 3'd6
  } kind_e;

  typedef enum logic [1:0] {
    ERR_NONE     = 2'd0,
    ERR_BAD_CHAR = 2'd1,
    ERR_LONG_NUM = 2'd2,
    ERR_TOO_MANY = 2'd3
  } err_e;

  typedef struct packed {
    kind_e       kind;
    logic [30:0] value;
    logic [7:0]  col;
    logic [5:0]  len;
    logic [2:0]  chan;
    err_e        err;
  } res_t;

  typedef struct packed {
    logic valid;
    res_t res;
  } out_t;

  function automatic res_t mk_res(kind_e kind, logic [30:0] value, logic [7:0] col,
                                  logic [5:0] len, logic [2:0] chan, err_e err);
    res_t r;
    r.kind  = kind;
    r.value = value;
    r.col   = col;
    r.len   = len;
    r.chan  = chan;
    r.err   = err;
    return r;
  endfunction

endpackage

// File: rtl/core/alt_scan.sv
module alt_scan (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                step_i,
  input  logic [7:0]          ch_i,
  input  logic                eol_i,
  input  logic [6:0]          max_tokens_i,
  output alt_pkg::out_t       slot0_o,
  output alt_pkg::out_t       slot1_o
);

  typedef enum logic [4:0] {
    MODE_IDLE   = 5'b00001,
    MODE_NUMBER = 5'b00010,
    MODE_IDENT  = 5'b00100,
    MODE_DONE   = 5'b01000,
    MODE_ERROR  = 5'b10000
  } mode_e;

  typedef struct packed {
    logic last_o;
    logic oct_stop;
    logic dec_stop;
  } flags_t;

  typedef struct packed {
    flags_t      flags;
    logic [30:0] dec;
    logic [30:0] oct;
  } num_t;

  typedef struct packed {
    mode_e         mode;
    logic [7:0]    column;
    logic [7:0]    tstart;
    logic [5:0]    tlen;
    num_t          num;
    logic [7:0]    first;
    logic [6:0]    count;
    alt_pkg::err_e lerr;
  } st_t;

  localparam logic [2:0] LOOP_U = 3'd0;
  localparam logic [2:0] LOOP_F = 3'd1;
  localparam logic [2:0] LOOP_E = 3'd2;
  localparam logic [2:0] LOOP_H = 3'd3;
  localparam logic [2:0] LOOP_L = 3'd4;
  localparam logic [2:0] LOOP_V = 3'd5;
  localparam logic [2:0] LOOP_R = 3'd6;

  localparam st_t StClear = '{mode: MODE_IDLE, lerr: alt_pkg::ERR_NONE, default: '0};

  st_t           st_q, st_d;
  alt_pkg::out_t s0, s1, fl;
  alt_pkg::res_t r;
  num_t          nm;
  logic          go_on, emit;
  logic [5:0]    tlen_inc;
  logic [7:0]    c;
  logic          is_dig, is_alpha, is_ident_ch, is_o;

  // One digit (or letter O) of a number; accumulators saturate at the top value.
  function automatic num_t num_step(num_t a, logic [7:0] ch);
    num_t        n;
    logic [34:0] m10;
    logic [33:0] m8;
    n   = a;
    m10 = ({4'b0, a.dec} << 3) + ({4'b0, a.dec} << 1) + 35'(ch[3:0]);
    m8  = {a.oct, 3'b000} + 34'(ch[3:0]);
    if (ch == "O" || ch == "o") begin
      n.flags = '{last_o: 1'b1, oct_stop: 1'b1, dec_stop: 1'b1};
    end else begin
      n.flags.last_o = 1'b0;
      if (!a.flags.dec_stop) begin
        n.dec = (m10 > 35'(alt_pkg::SatMax)) ? alt_pkg::SatMax : m10[30:0];
      end
      if (ch >= "8") begin
        n.flags.oct_stop = 1'b1;
      end
      if (!n.flags.oct_stop) begin
        n.oct = (m8 > 34'(alt_pkg::SatMax)) ? alt_pkg::SatMax : m8[30:0];
      end
    end
    return n;
  endfunction

  // Bit 3 flags a loop designator letter, the low bits give its channel.
  function automatic logic [3:0] loop_code(logic [7:0] ch);
    logic [7:0] uc;
    logic [3:0] lc;
    uc = (ch inside {["a":"z"]}) ? ch - 8'd32 : ch;
    case (uc)
      "U":     lc = {1'b1, LOOP_U};
      "F":     lc = {1'b1, LOOP_F};
      "E":     lc = {1'b1, LOOP_E};
      "H":     lc = {1'b1, LOOP_H};
      "L":     lc = {1'b1, LOOP_L};
      "V":     lc = {1'b1, LOOP_V};
      "R":     lc = {1'b1, LOOP_R};
      default: lc = 4'b0000;
    endcase
    return lc;
  endfunction

  function automatic alt_pkg::out_t flush_out(st_t s);
    alt_pkg::out_t o;
    logic [3:0]    lc;
    o  = '0;
    lc = loop_code(s.first);
    case (s.mode)
      MODE_NUMBER: begin
        o.valid = 1'b1;
        o.res   = alt_pkg::mk_res(alt_pkg::KIND_NUMBER,
                                  s.num.flags.last_o ? s.num.oct : s.num.dec,
                                  s.tstart, s.tlen, 3'd0, alt_pkg::ERR_NONE);
      end
      MODE_IDENT: begin
        o.valid = 1'b1;
        if (s.tlen == 6'd1 && lc[3]) begin
          o.res = alt_pkg::mk_res(alt_pkg::KIND_LOOP, '0, s.tstart, 6'd1, lc[2:0],
                                  alt_pkg::ERR_NONE);
        end else begin
          o.res = alt_pkg::mk_res(alt_pkg::KIND_MNEMONIC, '0, s.tstart, s.tlen, 3'd0,
                                  alt_pkg::ERR_NONE);
        end
      end
      default: o = '0;
    endcase
    return o;
  endfunction

  assign c           = ch_i;
  assign is_dig      = c inside {["0":"9"]};
  assign is_alpha    = c inside {["A":"Z"], ["a":"z"]};
  assign is_ident_ch = is_alpha || is_dig || c == "_";
  assign is_o        = c == "O" || c == "o";
  assign tlen_inc    = st_q.tlen + 6'd1;

  always_comb begin
    st_d  = st_q;
    s0    = '0;
    s1    = '0;
    fl    = '0;
    r     = '0;
    nm    = '0;
    go_on = 1'b0;
    emit  = 1'b0;
    if (step_i) begin
      if (eol_i) begin
        fl = flush_out(st_q);
        r  = alt_pkg::mk_res(alt_pkg::KIND_LINE_END, 31'(st_q.count), st_q.column,
                             6'd0, 3'd0, st_q.lerr);
        if (fl.valid) begin
          s0 = fl;
          s1 = '{valid: 1'b1, res: r};
        end else begin
          s0 = '{valid: 1'b1, res: r};
        end
        st_d = StClear;
      end else if (st_q.column < alt_pkg::ColW'(alt_pkg::LastCol)) begin
        st_d.column = st_q.column + 8'd1;
        case (st_q.mode)
          MODE_IDLE: go_on = 1'b1;
          MODE_NUMBER: begin
            if (is_dig || is_o) begin
              st_d.num  = num_step(st_q.num, c);
              st_d.tlen = tlen_inc;
              if (tlen_inc >= 6'(alt_pkg::NumberLimit)) begin
                s0 = '{valid: 1'b1,
                       res: alt_pkg::mk_res(alt_pkg::KIND_ERROR, '0, st_q.tstart,
                                            6'(alt_pkg::NumberLimit), 3'd0,
                                            alt_pkg::ERR_LONG_NUM)};
                st_d.mode = MODE_ERROR;
                st_d.lerr = alt_pkg::ERR_LONG_NUM;
              end
            end else begin
              fl        = flush_out(st_q);
              s0        = fl;
              st_d.mode = MODE_IDLE;
              go_on     = 1'b1;
            end
          end
          MODE_IDENT: begin
            if (is_ident_ch && st_q.tlen < 6'(alt_pkg::IdentMax)) begin
              st_d.tlen = tlen_inc;
            end else if (c == ":") begin
              s0 = '{valid: 1'b1,
                     res: alt_pkg::mk_res(alt_pkg::KIND_LABEL, '0, st_q.tstart, st_q.tlen,
                                          3'd0, alt_pkg::ERR_NONE)};
              st_d.mode = MODE_IDLE;
            end else begin
              fl        = flush_out(st_q);
              s0        = fl;
              st_d.mode = MODE_IDLE;
              go_on     = 1'b1;
            end
          end
          default: go_on = 1'b0;
        endcase

        if (go_on) begin
          if (c == " " || c == 8'h09) begin
            emit = 1'b0;
          end else if (c == ";" || c == 8'h0D || c == 8'h0A || c == 8'h00) begin
            st_d.mode = MODE_DONE;
          end else if (st_q.count >= max_tokens_i) begin
            emit      = 1'b1;
            r         = alt_pkg::mk_res(alt_pkg::KIND_ERROR, '0, st_q.column, 6'd1, 3'd0,
                                        alt_pkg::ERR_TOO_MANY);
            st_d.mode = MODE_ERROR;
            st_d.lerr = alt_pkg::ERR_TOO_MANY;
          end else if (c == ",") begin
            emit       = 1'b1;
            r          = alt_pkg::mk_res(alt_pkg::KIND_COMMA, '0, st_q.column, 6'd1, 3'd0,
                                         alt_pkg::ERR_NONE);
            st_d.count = st_q.count + 7'd1;
          end else if (is_dig) begin
            nm          = '0;
            st_d.num    = num_step(nm, c);
            st_d.count  = st_q.count + 7'd1;
            st_d.mode   = MODE_NUMBER;
            st_d.tstart = st_q.column;
            st_d.tlen   = 6'd1;
          end else if (is_alpha || c == "_") begin
            st_d.count  = st_q.count + 7'd1;
            st_d.mode   = MODE_IDENT;
            st_d.tstart = st_q.column;
            st_d.tlen   = 6'd1;
            st_d.first  = c;
          end else begin
            emit      = 1'b1;
            r         = alt_pkg::mk_res(alt_pkg::KIND_ERROR, '0, st_q.column, 6'd1, 3'd0,
                                        alt_pkg::ERR_BAD_CHAR);
            st_d.mode = MODE_ERROR;
            st_d.lerr = alt_pkg::ERR_BAD_CHAR;
          end
          // A flushed token goes first, so a new result takes the second slot.
          if (emit) begin
            if (fl.valid) begin
              s1 = '{valid: 1'b1, res: r};
            end else begin
              s0 = '{valid: 1'b1, res: r};
            end
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= StClear;
    end else begin
      st_q <= st_d;
    end
  end

  assign slot0_o = s0;
  assign slot1_o = s1;

endmodule

// File: rtl/core/alt_rq.sv
module alt_rq (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  alt_pkg::out_t             push0_i,
  input  alt_pkg::out_t             push1_i,
  input  logic                      pop_ready_i,
  output logic                      head_valid_o,
  output alt_pkg::res_t             head_o,
  output logic                      room_o
);

  alt_pkg::res_t                    mem_q [alt_pkg::QDepth];
  logic [alt_pkg::QPtrW-1:0]        wr_q, wr_d, rd_q, rd_d;
  logic [alt_pkg::QCntW-1:0]        cnt_q, cnt_d;
  logic                             pop;
  logic [1:0]                       n_push;

  assign n_push = {1'b0, push0_i.valid} + {1'b0, push1_i.valid};
  assign pop    = (cnt_q != '0) && pop_ready_i;
  assign wr_d   = wr_q + alt_pkg::QPtrW'(n_push);
  assign rd_d   = rd_q + alt_pkg::QPtrW'(pop);
  assign cnt_d  = cnt_q + alt_pkg::QCntW'(n_push) - alt_pkg::QCntW'(pop);

  always_ff @(posedge clk_i) begin
    if (push0_i.valid) begin
      mem_q[wr_q] <= push0_i.res;
    end
    if (push1_i.valid) begin
      mem_q[wr_q + alt_pkg::QPtrW'(1)] <= push1_i.res;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  assign head_valid_o = cnt_q != '0;
  assign head_o       = mem_q[rd_q];
  assign room_o       = cnt_q <= alt_pkg::QCntW'(alt_pkg::QDepth - 2);

endmodule

// File: rtl/core/assembly_line_tokenizer.sv
// Assembly line tokenizer: one source character per request on the slave stream,
// tokens out on the master stream.
// Slave stream: tdata carries the character byte, tlast marks the end of a line; a
// request with tlast set flushes any pending token and yields a line end result that
// carries the token count and the error code of that line (its tdata byte is unused).
// Master stream: tuser carries the token kind, tdata the value, start column, length,
// loop channel and error code.
// Configuration: a write on the cfg channel sets the token limit per line (reset 16).
// It is taken in every cycle and must only be written while the block is idle.
// Results are formed combinationally from the accepted character and are written
// into the result queue, whose head drives the master side. Throughput: one
// character per cycle while the four-entry result queue has at least two free
// entries; a character that ends one token and starts a comma or error yields two results.
// When the receiver stalls, results collect in the queue and tready on the slave side
// falls once fewer than two entries are free.
// Reset clears the line state, empties the queue and sets the limit back to 16.
module assembly_line_tokenizer (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [7:0]                    s_axis_tdata,   // [7:0] ch
  input  logic                          s_axis_tlast,
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // [30:0] value, [38:31] start_column, [44:39] length, [47:45] loop_channel,
  // [49:48] error_code, [55:50] zero
  output logic [alt_pkg::OutDataW-1:0]  m_axis_tdata,
  output logic [alt_pkg::OutUserW-1:0]  m_axis_tuser,   // [2:0] kind
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [6:0]                    cfg_data_i
);

  logic          step;
  logic          room;
  logic [6:0]    max_tokens_q;
  alt_pkg::out_t slot0, slot1;
  alt_pkg::res_t head;

  assign cfg_ready_o   = 1'b1;
  assign s_axis_tready = room;
  assign step          = s_axis_tvalid && room;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_tokens_q <= alt_pkg::MaxTokensReset;
    end else if (cfg_valid_i) begin
      max_tokens_q <= cfg_data_i;
    end
  end

  alt_scan u_scan (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .step_i       (step),
    .ch_i         (s_axis_tdata),
    .eol_i        (s_axis_tlast),
    .max_tokens_i (max_tokens_q),
    .slot0_o      (slot0),
    .slot1_o      (slot1)
  );

  alt_rq u_rq (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push0_i      (slot0),
    .push1_i      (slot1),
    .pop_ready_i  (m_axis_tready),
    .head_valid_o (m_axis_tvalid),
    .head_o       (head),
    .room_o       (room)
  );

  assign m_axis_tdata = {6'b000000, head.err, head.chan, head.len, head.col, head.value};
  assign m_axis_tuser = head.kind;

endmodule

// File: rtl/core/alt_checker.sv
module alt_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          s_axis_tvalid,
  input logic                          s_axis_tready,
  input logic                          m_axis_tvalid,
  input logic                          m_axis_tready,
  input logic [alt_pkg::OutDataW-1:0]  m_axis_tdata,
  input logic [alt_pkg::OutUserW-1:0]  m_axis_tuser
);

  // A stalled result keeps its kind and payload.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
                                        && $stable(m_axis_tuser))
    else $error("stalled result changed");

  // The padding bits above the error code are always zero.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[55:50] == 6'd0)
    else $error("tdata padding not zero");

  // Only a loop designator carries a loop channel.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser != alt_pkg::KIND_LOOP |-> m_axis_tdata[47:45] == 3'd0)
    else $error("loop channel on a non-loop token");

  // Only errors and line ends carry an error code.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser != alt_pkg::KIND_ERROR
      && m_axis_tuser != alt_pkg::KIND_LINE_END |-> m_axis_tdata[49:48] == 2'd0)
    else $error("error code on a plain token");

  // With no result waiting, a request is always taken.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && !m_axis_tvalid |-> s_axis_tready)
    else $error("request refused while no result is pending");

endmodule

bind assembly_line_tokenizer alt_checker u_alt_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);
